@@ design/sca_pkg.sv @@
// ----------------------------------------------------------------------------
// sca_pkg
// Shared types, codes and helpers for the three channel scan averager.
// ----------------------------------------------------------------------------
package sca_pkg;

   localparam int SAMPLE_W = 10;
   localparam int CHAN_W   = 2;
   localparam int SAMPLE_MAX = 1023;
   localparam int NUM_CHAN = 3;

   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_READ   = 1'b1
   } cmd_type;

   typedef enum logic [CHAN_W-1:0] {
      CH_AN13 = 2'd0,
      CH_AN14 = 2'd1,
      CH_AN15 = 2'd2
   } chan_type;

   // Request state handed from the front end to the accumulator stage.
   typedef struct packed {
      logic                valid;
      cmd_type             cmd;
      chan_type            chan;
      logic [SAMPLE_W-1:0] sample;
      logic                old_valid;
      chan_type            next_chan;
   } s1_ctrl_type;

   // Scan order is AN15, AN14, AN13, then back to AN15.
   function automatic chan_type scan_next(input chan_type ch);
      chan_type nxt;
      unique case (ch)
         CH_AN15: nxt = CH_AN14;
         CH_AN14: nxt = CH_AN13;
         CH_AN13: nxt = CH_AN15;
         default: nxt = CH_AN15;
      endcase
      return nxt;
   endfunction

endpackage

@@ design/sca_ring.sv @@
// ----------------------------------------------------------------------------
// sca_ring
// Sample ring storage for all channels: one write port, one registered read.
// ----------------------------------------------------------------------------
module sca_ring #(
   parameter int DEPTH = 48,
   parameter int AW    = 6
) (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [AW-1:0]                rd_addr,
   output logic [sca_pkg::SAMPLE_W-1:0] rd_data,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic [sca_pkg::SAMPLE_W-1:0] wr_data
);
   import sca_pkg::*;

   logic [SAMPLE_W-1:0] ring_mem_ff [DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/sca_front.sv @@
// ----------------------------------------------------------------------------
// sca_front
// Request intake: channel selection, ring write pointers, fill flags and the
// stage register that waits for the ring read data.
// ----------------------------------------------------------------------------
module sca_front #(
   parameter int WINDOW = 16,
   parameter int AW     = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_cmd,
   input  logic [sca_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [sca_pkg::CHAN_W-1:0]   req_channel,
   input  logic                         out_free,
   output logic                         rd_en,
   output logic [AW-1:0]                rd_addr,
   output sca_pkg::s1_ctrl_type         s1_ctrl,
   output logic [AW-1:0]                s1_addr
);
   import sca_pkg::*;

   localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam logic [PW-1:0] WP_LAST = PW'(WINDOW - 1);

   chan_type     sel_ff, sel_in;
   logic [PW-1:0] wp_ff [NUM_CHAN];
   logic [PW-1:0] wp_in [NUM_CHAN];
   logic [NUM_CHAN-1:0] full_ff, full_in;
   s1_ctrl_type  s1_ff, s1_in;
   logic [AW-1:0] s1_addr_ff, s1_addr_in;

   logic         accept;
   cmd_type      cmd_c;
   chan_type     req_chan_c;
   chan_type     chan_c;
   logic [PW-1:0] wp_cur;
   logic [PW-1:0] wp_next;

   assign req_ready = !s1_ff.valid || out_free;
   assign accept    = req_valid && req_ready;
   assign cmd_c     = cmd_type'(req_cmd);

   // An out of range channel code on a read falls back to AN13.
   assign req_chan_c = (req_channel > CH_AN15) ? CH_AN13 : chan_type'(req_channel);
   assign chan_c     = (cmd_c == CMD_READ) ? req_chan_c : sel_ff;
   assign wp_cur     = wp_ff[chan_c];
   assign wp_next    = (wp_cur == WP_LAST) ? '0 : PW'(wp_cur + 1'b1);

   assign rd_en   = accept;
   assign rd_addr = AW'(int'(chan_c) * WINDOW + int'(wp_cur));

   always_comb begin
      sel_in     = sel_ff;
      full_in    = full_ff;
      s1_addr_in = s1_addr_ff;
      s1_in      = s1_ff;
      for (int i = 0; i < NUM_CHAN; i++) begin
         wp_in[i] = wp_ff[i];
      end
      if (req_ready) begin
         s1_in.valid = req_valid;
      end
      if (accept) begin
         s1_in.cmd       = cmd_c;
         s1_in.chan      = chan_c;
         s1_in.sample    = req_sample;
         // The slot under the pointer holds data only once the ring wrapped.
         s1_in.old_valid = full_ff[chan_c];
         s1_in.next_chan = sel_ff;
         s1_addr_in      = rd_addr;
         if (cmd_c == CMD_SAMPLE) begin
            wp_in[chan_c] = wp_next;
            if (wp_cur == WP_LAST) begin
               full_in[chan_c] = 1'b1;
            end
            sel_in          = scan_next(sel_ff);
            s1_in.next_chan = scan_next(sel_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= CH_AN15;
         full_ff  <= '0;
         s1_ff    <= '0;
         for (int i = 0; i < NUM_CHAN; i++) begin
            wp_ff[i] <= '0;
         end
      end else begin
         sel_ff   <= sel_in;
         full_ff  <= full_in;
         s1_ff    <= s1_in;
         for (int i = 0; i < NUM_CHAN; i++) begin
            wp_ff[i] <= wp_in[i];
         end
      end
      s1_addr_ff <= s1_addr_in;
   end

   assign s1_ctrl = s1_ff;
   assign s1_addr = s1_addr_ff;

endmodule

@@ design/sca_accum.sv @@
// ----------------------------------------------------------------------------
// sca_accum
// Running sums per channel, mean by reciprocal multiply, and the result
// register.
// ----------------------------------------------------------------------------
module sca_accum #(
   parameter int WINDOW = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sca_pkg::s1_ctrl_type         s1_ctrl,
   input  logic [sca_pkg::SAMPLE_W-1:0] rd_data,
   output logic                         out_free,
   output logic                         advance,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [sca_pkg::SAMPLE_W-1:0] rsp_mean,
   output logic [sca_pkg::CHAN_W-1:0]   rsp_next_channel
);
   import sca_pkg::*;

   localparam int LW    = $clog2(WINDOW);
   localparam int SW    = SAMPLE_W + LW;
   localparam int SHIFT = SW + LW;
   // Rounded-up reciprocal; exact floor division for every SW-bit sum.
   localparam logic [SW:0] MULT =
      (SW+1)'(((longint'(1) << SHIFT) + longint'(WINDOW) - 1) / longint'(WINDOW));
   localparam logic [SW-1:0] SUM_MAX = SW'(SAMPLE_MAX * WINDOW);

   logic [SW-1:0]       sum_ff [NUM_CHAN];
   logic [SW-1:0]       sum_in [NUM_CHAN];
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_mean_ff, rsp_mean_in;
   chan_type            rsp_next_ff, rsp_next_in;

   logic [SW-1:0]       sum_cur;
   logic [SAMPLE_W-1:0] old_sample;
   logic [SW:0]         sum_wide;
   logic [SW-1:0]       sum_new;
   logic [2*SW:0]       product;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign advance  = s1_ctrl.valid && out_free;

   assign sum_cur    = sum_ff[s1_ctrl.chan];
   assign old_sample = s1_ctrl.old_valid ? rd_data : '0;
   assign sum_wide   = (SW+1)'(sum_cur) - (SW+1)'(old_sample) + (SW+1)'(s1_ctrl.sample);
   assign sum_new    = sum_wide[SW-1:0];
   assign product    = (2*SW+1)'(sum_cur) * (2*SW+1)'(MULT);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_mean_in  = rsp_mean_ff;
      rsp_next_in  = rsp_next_ff;
      for (int i = 0; i < NUM_CHAN; i++) begin
         sum_in[i] = sum_ff[i];
      end
      if (out_free) begin
         rsp_valid_in = s1_ctrl.valid;
      end
      if (advance) begin
         rsp_next_in = s1_ctrl.next_chan;
         if (s1_ctrl.cmd == CMD_SAMPLE) begin
            sum_in[s1_ctrl.chan] = sum_new;
            rsp_mean_in          = '0;
         end else begin
            rsp_mean_in = product[SHIFT +: SAMPLE_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CHAN; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < NUM_CHAN; i++) begin
            sum_ff[i] <= sum_in[i];
         end
      end
      rsp_mean_ff <= rsp_mean_in;
      rsp_next_ff <= rsp_next_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mean         = rsp_mean_ff;
   assign rsp_next_channel = rsp_next_ff;

   // A window can never sum to more than WINDOW full-scale samples.
   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      advance && s1_ctrl.cmd == CMD_SAMPLE |-> sum_new <= SUM_MAX)
      else $error("running sum exceeds full scale window");

   // Only a sample leaving the stage may change a running sum.
   a_sum_hold: assert property (@(posedge clock) disable iff (reset)
      !(advance && s1_ctrl.cmd == CMD_SAMPLE) |=>
         $stable(sum_ff[0]) && $stable(sum_ff[1]) && $stable(sum_ff[2]))
      else $error("running sum changed without a sample");

   a_sample_mean_zero: assert property (@(posedge clock) disable iff (reset)
      advance && s1_ctrl.cmd == CMD_SAMPLE |=> rsp_mean_ff == '0)
      else $error("sample request produced a nonzero mean");

endmodule

@@ design/three_channel_scan_averager.sv @@
// ----------------------------------------------------------------------------
// three_channel_scan_averager
// Round-robin window averager for channels AN13, AN14 and AN15.
// A result is valid once its request has passed the stage and result registers.
// Throughput: one request per cycle while responses are taken; the ring read at
// acceptance and the sum update on advance form a two-stage read-modify-write.
// Reset selects AN15 and clears pointers, fill flags and sums; the ring memory
// itself is not swept, since slots not yet written read as zero via fill flags.
// ----------------------------------------------------------------------------
module three_channel_scan_averager #(
   parameter int WINDOW = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_cmd,
   input  logic [sca_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [sca_pkg::CHAN_W-1:0]   req_channel,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [sca_pkg::SAMPLE_W-1:0] rsp_mean,
   output logic [sca_pkg::CHAN_W-1:0]   rsp_next_channel
);
   import sca_pkg::*;

   localparam int DEPTH = NUM_CHAN * WINDOW;
   localparam int AW    = $clog2(DEPTH);

   s1_ctrl_type         s1_ctrl;
   logic [AW-1:0]       s1_addr;
   logic                out_free;
   logic                advance;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic [SAMPLE_W-1:0] rd_data;
   logic                wr_en;

   sca_front #(
      .WINDOW (WINDOW),
      .AW     (AW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_cmd     (req_cmd),
      .req_sample  (req_sample),
      .req_channel (req_channel),
      .out_free    (out_free),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .s1_ctrl     (s1_ctrl),
      .s1_addr     (s1_addr)
   );

   // The new sample lands in the ring as the stage hands off its result.
   assign wr_en = advance && (s1_ctrl.cmd == CMD_SAMPLE);

   sca_ring #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ring (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (s1_addr),
      .wr_data (s1_ctrl.sample)
   );

   sca_accum #(
      .WINDOW (WINDOW)
   ) u_accum (
      .clock            (clock),
      .reset            (reset),
      .s1_ctrl          (s1_ctrl),
      .rd_data          (rd_data),
      .out_free         (out_free),
      .advance          (advance),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mean         (rsp_mean),
      .rsp_next_channel (rsp_next_channel)
   );

   a_next_chan_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_next_channel != 2'd3)
      else $error("reported channel code is not a scanned channel");

   a_stall_interlock: assert property (@(posedge clock) disable iff (reset)
      s1_ctrl.valid && !out_free |-> !req_ready)
      else $error("request taken while the stage is blocked");

   a_ring_write_once: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> !$past(rd_en) || !s1_ctrl.valid || s1_ctrl.cmd == CMD_READ
         || s1_addr != $past(s1_addr))
      else $error("back-to-back samples hit the same ring slot");

endmodule
